@@ src/plau_pkg.sv @@
// Shared types, widths, constants and helper functions for the launch angle unit.
// No dependencies; imported by every module of the block.
package plau_pkg;

    localparam int ZW        = 25;   // angle accumulator, enough for 20 fraction bits
    localparam int CW        = 48;   // CORDIC x/y datapath
    localparam int NUM_W     = 54;   // 256*g*x^2
    localparam int DEN_W     = 32;   // v^2
    localparam int Q_W       = 27;   // quotient bits 26..0
    localparam int SQ_W      = 48;   // square root working width
    localparam int ROOT_W    = 24;
    localparam int A_W       = 27;
    localparam int SS_W      = 31;
    localparam int TABLE_LEN = 24;

    localparam logic [Q_W-1:0] Q_SAT = 27'd33554432;

    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_HALF_PI = 64'sd1686629713;

    localparam longint ATAN_Q30 [TABLE_LEN] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
        64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
        64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
        64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
        64'sd1024,      64'sd512,       64'sd256,       64'sd128
    };

    typedef struct packed {
        logic [15:0]        launch_speed;
        logic [14:0]        target_horizontal;
        logic signed [15:0] target_vertical;
    } t_req;

    typedef struct packed {
        logic [1:0]         solution_count;
        logic signed [15:0] flat_angle;
        logic signed [15:0] lofted_angle;
    } t_res;

    // per-request data carried alongside the arithmetic cells
    typedef struct packed {
        logic                  ok;
        logic                  down;
        logic                  rzero;
        logic [14:0]           x;
        logic signed [15:0]    y;
        logic signed [A_W-1:0] a;
        logic [SS_W-1:0]       ss;
    } t_side;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [ZW-1:0] z;
    } t_rot;

    // Q30 to frac bits, round half up
    function automatic logic signed [ZW-1:0] from_q30(input longint v, input int frac);
        longint r;
        r = (v + (longint'(1) << (29 - frac))) >>> (30 - frac);
        return ZW'(r);
    endfunction

    function automatic t_rot rot_step(input t_rot c, input int i,
                                      input logic signed [ZW-1:0] ang);
        t_rot                 n;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        dx = $signed(c.cy) >>> i;
        dy = $signed(c.cx) >>> i;
        if (c.cy[CW-1] == 1'b0) begin
            n.cx = c.cx + dx;
            n.cy = c.cy - dy;
            n.z  = c.z + ang;
        end else begin
            n.cx = c.cx - dx;
            n.cy = c.cy + dy;
            n.z  = c.z - ang;
        end
        return n;
    endfunction

endpackage

@@ src/plau_div_cell.sv @@
// One restoring-division cell: decides one quotient bit of 256*g*x^2 / v^2.
// Depends on plau_pkg.
module plau_div_cell #(
    parameter int BIT = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  plau_pkg::t_side            i_side,
    input  logic [plau_pkg::NUM_W-1:0] i_rem,
    input  logic [plau_pkg::DEN_W-1:0] i_den,
    input  logic [plau_pkg::Q_W-1:0]   i_q,
    output logic                       o_vld,
    output plau_pkg::t_side            o_side,
    output logic [plau_pkg::NUM_W-1:0] o_rem,
    output logic [plau_pkg::DEN_W-1:0] o_den,
    output logic [plau_pkg::Q_W-1:0]   o_q
);
    import plau_pkg::*;

    localparam int CMP_W = DEN_W + Q_W;

    logic [CMP_W-1:0] w_sub;
    logic             w_ge;
    logic [NUM_W-1:0] n_rem;
    logic [Q_W-1:0]   n_q;
    logic             r_vld;
    t_side            r_side;
    logic [NUM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_q;

    assign w_sub = CMP_W'(i_den) << BIT;
    assign w_ge  = CMP_W'(i_rem) >= w_sub;

    always_comb begin
        n_q      = i_q;
        n_q[BIT] = w_ge;
        n_rem    = w_ge ? (i_rem - NUM_W'(w_sub)) : i_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_side <= i_side;
        r_rem  <= n_rem;
        r_den  <= i_den;
        r_q    <= n_q;
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_q    = r_q;

endmodule

@@ src/plau_sqrt_cell.sv @@
// One integer square root cell: settles one root bit (digit pair 4^K).
// Depends on plau_pkg.
module plau_sqrt_cell #(
    parameter int K = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  plau_pkg::t_side           i_side,
    input  logic [plau_pkg::SQ_W-1:0] i_rem,
    input  logic [plau_pkg::SQ_W-1:0] i_root,
    output logic                      o_vld,
    output plau_pkg::t_side           o_side,
    output logic [plau_pkg::SQ_W-1:0] o_rem,
    output logic [plau_pkg::SQ_W-1:0] o_root
);
    import plau_pkg::*;

    logic [SQ_W-1:0] w_bit;
    logic [SQ_W-1:0] w_sum;
    logic            w_ge;
    logic [SQ_W-1:0] n_rem;
    logic [SQ_W-1:0] n_root;
    logic            r_vld;
    t_side           r_side;
    logic [SQ_W-1:0] r_rem;
    logic [SQ_W-1:0] r_root;

    assign w_bit = SQ_W'(1) << (2 * K);
    assign w_sum = i_root + w_bit;
    assign w_ge  = i_rem >= w_sum;

    always_comb begin
        if (w_ge) begin
            n_rem  = i_rem - w_sum;
            n_root = (i_root >> 1) + w_bit;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_side <= i_side;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

@@ src/plau_cordic_cell.sv @@
// One CORDIC vectoring cell, two lanes: alpha (asin term) and phi (target bearing).
// Depends on plau_pkg.
module plau_cordic_cell #(
    parameter int STAGE = 0,
    parameter int FRAC  = 13
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  plau_pkg::t_side i_side,
    input  plau_pkg::t_rot  i_alpha,
    input  plau_pkg::t_rot  i_phi,
    output logic            o_vld,
    output plau_pkg::t_side o_side,
    output plau_pkg::t_rot  o_alpha,
    output plau_pkg::t_rot  o_phi
);
    import plau_pkg::*;

    localparam logic signed [ZW-1:0] ANG = from_q30(ATAN_Q30[STAGE], FRAC);

    logic  r_vld;
    t_side r_side;
    t_rot  r_alpha;
    t_rot  r_phi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_side  <= i_side;
        r_alpha <= rot_step(i_alpha, STAGE, ANG);
        r_phi   <= rot_step(i_phi, STAGE, ANG);
    end

    assign o_vld   = r_vld;
    assign o_side  = r_side;
    assign o_alpha = r_alpha;
    assign o_phi   = r_phi;

endmodule

@@ src/projectile_launch_angles_unit.sv @@
// Drag-free launch angle solver: one request per cycle, never busy.
// The result strobe follows 3 setup stages, 27 divider cells, 3 stages, 24 root
// cells, the CORDIC cells and the output register. Throughput one request per cycle.
// Synchronous active-low reset clears the pipeline valids and sets g to 9800.
// Depends on plau_pkg and the div, sqrt and cordic cells.
module projectile_launch_angles_unit #(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  plau_pkg::t_req i_req,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata,
    output logic           o_strobe,
    output plau_pkg::t_res o_res
);
    import plau_pkg::*;

    localparam logic signed [ZW-1:0] HALF_PI = from_q30(Q30_HALF_PI, ANGLE_FRAC_BITS);
    localparam logic signed [ZW-1:0] PI_A    = from_q30(Q30_PI, ANGLE_FRAC_BITS);
    localparam int GX_W = 31;

    logic                 w_acc;
    logic [15:0]          r_grav;

    logic                 r_vld0;
    t_req                 r_req0;

    logic                 r_vld1;
    t_side                n_side1;
    t_side                r_side1;
    logic [GX_W-1:0]      r_gx1;
    logic [29:0]          r_xx1;
    logic [30:0]          r_yy1;
    logic [DEN_W-1:0]     r_vv1;
    logic signed [31:0]   w_yy;
    logic [NUM_W-9:0]     w_n;

    logic                 r_vld2;
    t_side                n_side2;
    t_side                r_side2;
    logic [NUM_W-1:0]     r_num2;
    logic [DEN_W-1:0]     r_den2;

    logic                 div_vld  [0:Q_W];
    t_side                div_side [0:Q_W];
    logic [NUM_W-1:0]     div_rem  [0:Q_W];
    logic [DEN_W-1:0]     div_den  [0:Q_W];
    logic [Q_W-1:0]       div_q    [0:Q_W];

    logic [Q_W-1:0]       w_qs;
    logic signed [A_W-1:0] w_a;
    t_side                n_sideA;
    logic                 r_vldA;
    t_side                r_sideA;

    logic signed [2*A_W-1:0] w_aa;
    logic                 r_vldB;
    t_side                r_sideB;
    logic [2*A_W-1:0]     r_aaB;

    logic [2*A_W-1:0]     w_s;
    logic                 w_far;
    t_side                n_sideC;
    logic                 r_vldC;
    t_side                r_sideC;
    logic [SQ_W-1:0]      r_diffC;

    logic                 sq_vld  [0:ROOT_W];
    t_side                sq_side [0:ROOT_W];
    logic [SQ_W-1:0]      sq_rem  [0:ROOT_W];
    logic [SQ_W-1:0]      sq_root [0:ROOT_W];

    logic                 cd_vld   [0:CORDIC_STAGES];
    t_side                cd_side  [0:CORDIC_STAGES];
    t_rot                 cd_alpha [0:CORDIC_STAGES];
    t_rot                 cd_phi   [0:CORDIC_STAGES];

    t_side                w_fs;
    logic signed [ZW-1:0] w_alpha;
    logic signed [ZW-1:0] w_phi;
    logic signed [ZW:0]   w_sum1;
    logic signed [ZW:0]   w_sum2;
    logic signed [ZW:0]   w_half1;
    logic signed [ZW:0]   w_half2;
    t_res                 n_res;
    logic                 r_strobe;
    t_res                 r_res;

    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= 16'd9800;
        end else if (i_cfg_we) begin
            r_grav <= i_cfg_wdata;
        end
    end

    // setup: squares and g*x
    assign w_yy = r_req0.target_vertical * r_req0.target_vertical;

    always_comb begin
        n_side1    = '0;
        n_side1.ok = (r_req0.launch_speed != 16'd0) &&
                     !((r_req0.target_horizontal == 15'd0) &&
                       (r_req0.target_vertical == 16'sd0));
        n_side1.x  = r_req0.target_horizontal;
        n_side1.y  = r_req0.target_vertical;
        n_side2    = r_side1;
        n_side2.ss = SS_W'(r_xx1) + r_yy1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld0 <= w_acc;
            r_vld1 <= r_vld0;
            r_vld2 <= r_vld1;
        end
        r_req0  <= i_req;
        r_gx1   <= GX_W'(r_grav) * GX_W'(r_req0.target_horizontal);
        r_xx1   <= 30'(r_req0.target_horizontal) * 30'(r_req0.target_horizontal);
        r_yy1   <= w_yy[30:0];
        r_vv1   <= DEN_W'(r_req0.launch_speed) * DEN_W'(r_req0.launch_speed);
        r_side1 <= n_side1;
        r_num2  <= {w_n, 8'b0};
        r_den2  <= r_vv1;
        r_side2 <= n_side2;
    end

    assign w_n = (NUM_W-8)'(r_gx1) * (NUM_W-8)'(r_side1.x);

    // divider chain, quotient bit 26 first
    assign div_vld[0]  = r_vld2;
    assign div_side[0] = r_side2;
    assign div_rem[0]  = r_num2;
    assign div_den[0]  = r_den2;
    assign div_q[0]    = '0;

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        plau_div_cell #(.BIT(Q_W - 1 - j)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (div_vld[j]),
            .i_side (div_side[j]),
            .i_rem  (div_rem[j]),
            .i_den  (div_den[j]),
            .i_q    (div_q[j]),
            .o_vld  (div_vld[j+1]),
            .o_side (div_side[j+1]),
            .o_rem  (div_rem[j+1]),
            .o_den  (div_den[j+1]),
            .o_q    (div_q[j+1])
        );
    end

    // a = 256*y + min(q, 2^25), then a^2
    assign w_qs = (div_q[Q_W] > Q_SAT) ? Q_SAT : div_q[Q_W];
    assign w_a  = $signed({{3{div_side[Q_W].y[15]}}, div_side[Q_W].y, 8'b0}) +
                  $signed(w_qs);
    assign w_aa = r_sideA.a * r_sideA.a;

    assign w_s   = (2*A_W)'({r_sideB.ss, 16'b0});
    assign w_far = !r_sideB.a[A_W-1] && (r_sideB.a != '0) && (r_aaB > w_s);

    always_comb begin
        n_sideA       = div_side[Q_W];
        n_sideA.a     = w_a;
        n_sideC       = r_sideB;
        n_sideC.ok    = r_sideB.ok && !w_far;
        n_sideC.down  = r_sideB.a[A_W-1] && (r_aaB >= w_s);
        n_sideC.rzero = (r_aaB == w_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vldA <= 1'b0;
            r_vldB <= 1'b0;
            r_vldC <= 1'b0;
        end else begin
            r_vldA <= div_vld[Q_W];
            r_vldB <= r_vldA;
            r_vldC <= r_vldB;
        end
        r_sideA   <= n_sideA;
        r_sideB   <= r_sideA;
        r_aaB     <= w_aa;
        r_sideC   <= n_sideC;
        r_diffC   <= SQ_W'(w_s) - SQ_W'(r_aaB);
    end

    // square root chain, digit pair 4^23 first
    assign sq_vld[0]  = r_vldC;
    assign sq_side[0] = r_sideC;
    assign sq_rem[0]  = r_diffC;
    assign sq_root[0] = '0;

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        plau_sqrt_cell #(.K(ROOT_W - 1 - j)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (sq_vld[j]),
            .i_side (sq_side[j]),
            .i_rem  (sq_rem[j]),
            .i_root (sq_root[j]),
            .o_vld  (sq_vld[j+1]),
            .o_side (sq_side[j+1]),
            .o_rem  (sq_rem[j+1]),
            .o_root (sq_root[j+1])
        );
    end

    // CORDIC inputs scaled by 2^16
    assign cd_vld[0]      = sq_vld[ROOT_W];
    assign cd_side[0]     = sq_side[ROOT_W];
    assign cd_alpha[0].cx = {8'b0, sq_root[ROOT_W][ROOT_W-1:0], 16'b0};
    assign cd_alpha[0].cy = {{(CW-A_W-16){sq_side[ROOT_W].a[A_W-1]}},
                             sq_side[ROOT_W].a, 16'b0};
    assign cd_alpha[0].z  = '0;
    assign cd_phi[0].cx   = {17'b0, sq_side[ROOT_W].x, 16'b0};
    assign cd_phi[0].cy   = {{16{sq_side[ROOT_W].y[15]}}, sq_side[ROOT_W].y, 16'b0};
    assign cd_phi[0].z    = '0;

    for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
        plau_cordic_cell #(.STAGE(j), .FRAC(ANGLE_FRAC_BITS)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (cd_vld[j]),
            .i_side (cd_side[j]),
            .i_alpha(cd_alpha[j]),
            .i_phi  (cd_phi[j]),
            .o_vld  (cd_vld[j+1]),
            .o_side (cd_side[j+1]),
            .o_alpha(cd_alpha[j+1]),
            .o_phi  (cd_phi[j+1])
        );
    end

    // vertical cases bypass the CORDIC result
    assign w_fs = cd_side[CORDIC_STAGES];

    always_comb begin
        if (w_fs.down) begin
            w_alpha = -HALF_PI;
        end else if (w_fs.rzero) begin
            w_alpha = HALF_PI;
        end else begin
            w_alpha = cd_alpha[CORDIC_STAGES].z;
        end
        if (w_fs.x == 15'd0) begin
            w_phi = w_fs.y[15] ? -HALF_PI : HALF_PI;
        end else begin
            w_phi = cd_phi[CORDIC_STAGES].z;
        end
        w_sum1  = (ZW+1)'(w_alpha) + (ZW+1)'(w_phi);
        w_sum2  = (ZW+1)'(PI_A) - (ZW+1)'(w_alpha) + (ZW+1)'(w_phi);
        w_half1 = w_sum1 >>> 1;
        w_half2 = w_sum2 >>> 1;
        n_res   = '0;
        if (w_fs.ok) begin
            n_res.solution_count = 2'd2;
            n_res.flat_angle     = w_half1[15:0];
            n_res.lofted_angle   = w_half2[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= cd_vld[CORDIC_STAGES];
        end
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

`ifndef ASSERT_OFF
    a_count_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_res.solution_count == 2'd0 || o_res.solution_count == 2'd2))
        else $error("bad solution count");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.solution_count == 2'd0) |->
            (o_res.flat_angle == 16'sd0 && o_res.lofted_angle == 16'sd0))
        else $error("angles not cleared without solution");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_strobe)
        else $error("strobe right after reset");
`endif

endmodule
